/* src/slfp_pkg.sv */
`default_nettype none
package slfp_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int REPORT_WIDTH = 32;
    localparam int CNT_NUM = 5;

    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;
    localparam logic [1:0] SEQ_LAST = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_LEN,
        PH_PAY,
        PH_TYPE,
        PH_SEQ
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_PAYLOAD,
        EV_DONE,
        EV_BAD_LEN,
        EV_BAD_TYPE
    } t_event;

    typedef enum logic [1:0] {
        CFG_MAX_PAYLOAD,
        CFG_TYPE_MIN,
        CFG_TYPE_MAX,
        CFG_SEQ_MASK
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CNT_BYTES,
        CNT_FRAMES,
        CNT_BAD_LEN,
        CNT_BAD_TYPE,
        CNT_REPEATS
    } t_cnt;

    typedef struct packed {
        logic [7:0]  max_payload;
        logic [7:0]  type_min;
        logic [7:0]  type_max;
        logic [23:0] seq_mask;
    } t_cfg;

    typedef struct packed {
        t_event                  event_res;
        logic [7:0]              out_byte;
        logic [7:0]              byte_pos;
        logic [7:0]              frame_len;
        logic [7:0]              msg_type;
        logic [23:0]             seq_num;
        logic                    is_repeat;
        logic [REPORT_WIDTH-1:0] count_bytes;
        logic [REPORT_WIDTH-1:0] count_frames;
        logic [REPORT_WIDTH-1:0] count_bad_len;
        logic [REPORT_WIDTH-1:0] count_bad_type;
        logic [REPORT_WIDTH-1:0] count_repeats;
    } t_result;

    typedef struct packed {
        logic [1:0] matched;
        logic       done;
    } t_hunt;

    // One step of the sync word search; a mismatch falls back to a single
    // matched byte when the byte itself opens the sync word.
    function automatic t_hunt hunt_step(input logic [1:0] matched, input logic [7:0] b);
        t_hunt h;
        logic [7:0] expect_byte;
        expect_byte = matched[0] ? SYNC_B : SYNC_A;
        if (b == expect_byte) begin
            h.matched = matched + 2'd1;
            h.done    = (matched == 2'd3);
        end else begin
            h.matched = (b == SYNC_A) ? 2'd1 : 2'd0;
            h.done    = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

/* src/slfp_core.sv */
`default_nettype none
module slfp_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire [7:0]            i_byte,
    input  slfp_pkg::t_cfg       i_cfg,
    output slfp_pkg::t_result    o_res
);
    import slfp_pkg::*;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_matched, n_matched;
    logic [7:0]          r_len, n_len;
    logic [7:0]          r_index, n_index;
    logic [7:0]          r_type, n_type;
    logic [1:0]          r_seen, n_seen;
    logic [23:0]         r_accum, n_accum;
    logic                r_have_prev, n_have_prev;
    logic [7:0]          r_prev_type, n_prev_type;
    logic [23:0]         r_prev_seq, n_prev_seq;
    logic [COUNT_WIDTH-1:0] r_cnt [CNT_NUM];
    logic [COUNT_WIDTH-1:0] n_cnt [CNT_NUM];
    logic [CNT_NUM-1:0]  w_inc;

    logic        w_bad_len;
    logic        w_bad_type;
    logic [23:0] w_accum;
    logic [23:0] w_seq;
    logic        w_repeat;
    logic [7:0]  w_next_index;
    t_hunt       w_hunt_cont;
    t_hunt       w_hunt_fresh;

    assign w_bad_len    = (i_byte == 8'd0) || (i_byte > i_cfg.max_payload);
    assign w_bad_type   = (i_byte < i_cfg.type_min) || (i_byte > i_cfg.type_max);
    assign w_accum      = {r_accum[15:0], i_byte};
    assign w_seq        = w_accum & i_cfg.seq_mask;
    assign w_repeat     = r_have_prev && (r_prev_type == r_type) && (r_prev_seq == w_seq);
    assign w_next_index = r_index + 8'd1;
    assign w_hunt_cont  = hunt_step(r_matched, i_byte);
    assign w_hunt_fresh = hunt_step(2'd0, i_byte);

    always_comb begin
        n_phase     = r_phase;
        n_matched   = r_matched;
        n_len       = r_len;
        n_index     = r_index;
        n_type      = r_type;
        n_seen      = r_seen;
        n_accum     = r_accum;
        n_have_prev = r_have_prev;
        n_prev_type = r_prev_type;
        n_prev_seq  = r_prev_seq;
        w_inc       = '0;
        w_inc[CNT_BYTES] = 1'b1;
        unique case (r_phase)
            PH_SYNC: begin
                n_matched = w_hunt_cont.matched;
                if (w_hunt_cont.done) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (w_bad_len) begin
                    w_inc[CNT_BAD_LEN] = 1'b1;
                    n_phase   = w_hunt_fresh.done ? PH_LEN : PH_SYNC;
                    n_matched = w_hunt_fresh.matched;
                    n_len     = '0;
                    n_index   = '0;
                    n_type    = '0;
                    n_seen    = '0;
                    n_accum   = '0;
                end else begin
                    n_len   = i_byte;
                    n_index = '0;
                    n_phase = PH_PAY;
                end
            end
            PH_PAY: begin
                n_index = w_next_index;
                if (w_next_index == r_len) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (w_bad_type) begin
                    w_inc[CNT_BAD_TYPE] = 1'b1;
                    n_phase   = w_hunt_fresh.done ? PH_LEN : PH_SYNC;
                    n_matched = w_hunt_fresh.matched;
                    n_len     = '0;
                    n_index   = '0;
                    n_type    = '0;
                    n_seen    = '0;
                    n_accum   = '0;
                end else begin
                    n_type  = i_byte;
                    n_seen  = '0;
                    n_accum = '0;
                    n_phase = PH_SEQ;
                end
            end
            PH_SEQ: begin
                n_accum = w_accum;
                n_seen  = r_seen + 2'd1;
                if (r_seen == SEQ_LAST) begin
                    w_inc[CNT_FRAMES]  = 1'b1;
                    w_inc[CNT_REPEATS] = w_repeat;
                    n_have_prev = 1'b1;
                    n_prev_type = r_type;
                    n_prev_seq  = w_seq;
                    n_phase   = PH_SYNC;
                    n_matched = '0;
                    n_len     = '0;
                    n_index   = '0;
                    n_type    = '0;
                    n_seen    = '0;
                    n_accum   = '0;
                end
            end
            default: begin
                n_phase   = PH_SYNC;
                n_matched = '0;
                n_len     = '0;
                n_index   = '0;
                n_type    = '0;
                n_seen    = '0;
                n_accum   = '0;
            end
        endcase
        for (int k = 0; k < CNT_NUM; k++) begin
            n_cnt[k] = r_cnt[k] + COUNT_WIDTH'(w_inc[k]);
        end
    end

    always_comb begin
        o_res = '0;
        o_res.event_res = EV_NONE;
        unique case (r_phase)
            PH_LEN: begin
                if (w_bad_len) begin
                    o_res.event_res = EV_BAD_LEN;
                end
            end
            PH_PAY: begin
                o_res.event_res = EV_PAYLOAD;
                o_res.out_byte  = i_byte;
                o_res.byte_pos  = r_index;
                o_res.frame_len = r_len;
            end
            PH_TYPE: begin
                if (w_bad_type) begin
                    o_res.event_res = EV_BAD_TYPE;
                end
            end
            PH_SEQ: begin
                if (r_seen == SEQ_LAST) begin
                    o_res.event_res = EV_DONE;
                    o_res.frame_len = r_len;
                    o_res.msg_type  = r_type;
                    o_res.seq_num   = w_seq;
                    o_res.is_repeat = w_repeat;
                end
            end
            default: begin
                o_res.event_res = EV_NONE;
            end
        endcase
        o_res.count_bytes    = REPORT_WIDTH'(n_cnt[CNT_BYTES]);
        o_res.count_frames   = REPORT_WIDTH'(n_cnt[CNT_FRAMES]);
        o_res.count_bad_len  = REPORT_WIDTH'(n_cnt[CNT_BAD_LEN]);
        o_res.count_bad_type = REPORT_WIDTH'(n_cnt[CNT_BAD_TYPE]);
        o_res.count_repeats  = REPORT_WIDTH'(n_cnt[CNT_REPEATS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC;
            r_matched   <= '0;
            r_len       <= '0;
            r_index     <= '0;
            r_type      <= '0;
            r_seen      <= '0;
            r_accum     <= '0;
            r_have_prev <= 1'b0;
            r_prev_type <= '0;
            r_prev_seq  <= '0;
            for (int k = 0; k < CNT_NUM; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_matched   <= n_matched;
            r_len       <= n_len;
            r_index     <= n_index;
            r_type      <= n_type;
            r_seen      <= n_seen;
            r_accum     <= n_accum;
            r_have_prev <= n_have_prev;
            r_prev_type <= n_prev_type;
            r_prev_seq  <= n_prev_seq;
            for (int k = 0; k < CNT_NUM; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

endmodule
`default_nettype wire

/* src/sync_length_frame_parser.sv */
// Byte-serial parser for frames of the form AA 55 AA 55, length, payload,
// message type and a 24-bit big-endian sequence number.
// The input channel takes one received byte per beat (i_valid, o_stall);
// the output channel gives exactly one result beat per input beat
// (o_valid, i_stall), carrying the event, the streamed payload byte or the
// frame completion data, and the five statistics counters after that byte.
// The result is registered and is output in the cycle after acceptance.
// The parser takes one byte per cycle while the output is not stalled:
// the parser state and the result register update together per byte.
// When the receiver stalls, the pending result holds in the output register
// and o_stall rises in the same cycle, so no new byte is taken until the
// result leaves; a byte can be accepted in the cycle the result is taken.
// Synchronous reset returns the parser to the sync hunt, clears the counters
// and the previous-frame record, empties the output register and loads the
// configuration registers with their defaults. Configuration writes through
// i_cfg_we take effect at the next clock edge and must be made while idle.
`default_nettype none
module sync_length_frame_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_out_byte,
    output logic [7:0]  o_byte_pos,
    output logic [7:0]  o_frame_len,
    output logic [7:0]  o_msg_type,
    output logic [23:0] o_seq_num,
    output logic        o_is_repeat,
    output logic [31:0] o_count_bytes,
    output logic [31:0] o_count_frames,
    output logic [31:0] o_count_bad_len,
    output logic [31:0] o_count_bad_type,
    output logic [31:0] o_count_repeats,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [23:0] i_cfg_data
);
    import slfp_pkg::*;

    t_cfg    r_cfg;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;
    logic    w_in_acc;

    assign o_stall  = r_out_valid && i_stall;
    assign w_in_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_payload <= 8'd255;
            r_cfg.type_min    <= 8'd1;
            r_cfg.type_max    <= 8'd255;
            r_cfg.seq_mask    <= 24'hFFFFFF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data[7:0];
                CFG_TYPE_MIN:    r_cfg.type_min    <= i_cfg_data[7:0];
                CFG_TYPE_MAX:    r_cfg.type_max    <= i_cfg_data[7:0];
                CFG_SEQ_MASK:    r_cfg.seq_mask    <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    slfp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_in_acc),
        .i_byte  (i_rx_byte),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_in_acc || o_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_res      = r_res.event_res;
    assign o_out_byte       = r_res.out_byte;
    assign o_byte_pos       = r_res.byte_pos;
    assign o_frame_len      = r_res.frame_len;
    assign o_msg_type       = r_res.msg_type;
    assign o_seq_num        = r_res.seq_num;
    assign o_is_repeat      = r_res.is_repeat;
    assign o_count_bytes    = r_res.count_bytes;
    assign o_count_frames   = r_res.count_frames;
    assign o_count_bad_len  = r_res.count_bad_len;
    assign o_count_bad_type = r_res.count_bad_type;
    assign o_count_repeats  = r_res.count_repeats;

endmodule
`default_nettype wire

/* src/slfp_checker.sv */
`default_nettype none
module slfp_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input wire       o_valid,
    input wire       i_stall,
    input wire [2:0] o_event_res,
    input wire [7:0] o_out_byte,
    input wire [7:0] o_frame_len
);
    import slfp_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output beat present right after reset.");

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("Accepted byte did not produce a result beat one cycle later.");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_res) && $stable(o_out_byte))
        else $error("Stalled result beat changed.");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res != EV_PAYLOAD) |-> o_out_byte == 8'd0)
        else $error("Payload byte reported outside a payload event.");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res != EV_PAYLOAD) && (o_event_res != EV_DONE)
            |-> o_frame_len == 8'd0)
        else $error("Frame length reported outside payload or completion events.");

endmodule

bind sync_length_frame_parser slfp_checker u_slfp_checker (.*);
`default_nettype wire
